/* sv/tmcs_pkg.sv */
// Shared types and constants for the tiled mip-chain size block.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package tmcs_pkg;

    // Port widths of one texture description and of one result
    localparam int KIND_W  = 2;
    localparam int BPT_W   = 8;
    localparam int SIDE_W  = 15;
    localparam int LAYER_W = 12;
    localparam int TOTAL_W = 46;

    // Bytes per block: up to twice the bits per texel for 4x4 blocks
    localparam int BB_W = BPT_W + 1;

    // Layout rules
    localparam int TILE_BLOCKS  = 32;
    localparam int LINEAR_ALIGN = 256;
    localparam int LEVEL_ALIGN  = 4096;
    localparam int PACK_LIMIT   = 16;
    localparam int CUBE_FACES   = 6;

    // Defaults for the top-level parameters
    localparam int DEF_MAX_DIM   = 16384;
    localparam int DEF_MAX_DEPTH = 2048;

    // Texture kinds; the unused code falls back to plain 2D
    localparam logic [KIND_W-1:0] KIND_CUBE   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_VOLUME = 2'd2;

    // Token travelling down the chain of level cells
    typedef struct packed {
        logic valid;   // a texture occupies this slot
        logic active;  // its chain has not yet ended
        logic first;   // this slot holds the top level
    } lvl_ctrl_t;

    // Per-texture options, held for the whole pass
    typedef struct packed {
        logic comp;    // 4x4 block compressed
        logic tiled;   // tiled pitch, else linear pitch
        logic pack;    // packed mip tail
        logic mips;    // mip chain stored
    } item_flags_t;

endpackage

`default_nettype wire

/* sv/tmcs_level_cell.sv */
// One cell of the level chain: sizes one mip level through registered stages A
// and B and hands the running total and the next level's sides to its neighbour.
// Depends on tmcs_pkg.
`default_nettype none

module tmcs_level_cell #(
    parameter int MAX_DIM = tmcs_pkg::DEF_MAX_DIM,
    localparam int DIM_W  = $clog2(MAX_DIM + 1)
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  tmcs_pkg::item_flags_t        flags,
    input  logic [tmcs_pkg::BB_W-1:0]    block_bytes,
    input  logic [DIM_W-1:0]             pow_w,
    input  logic [DIM_W-1:0]             pow_h,
    input  tmcs_pkg::lvl_ctrl_t          prev_ctrl,
    input  logic [DIM_W-1:0]             prev_w,
    input  logic [DIM_W-1:0]             prev_h,
    input  logic [tmcs_pkg::TOTAL_W-1:0] prev_total,
    output tmcs_pkg::lvl_ctrl_t          next_ctrl,
    output logic [DIM_W-1:0]             next_w,
    output logic [DIM_W-1:0]             next_h,
    output logic [tmcs_pkg::TOTAL_W-1:0] next_total
);
    import tmcs_pkg::*;

    localparam int WB_W    = DIM_W + 1;
    localparam int PITCH_W = WB_W + BB_W + 1;
    localparam int PROD_W  = PITCH_W + WB_W;
    localparam int LVL_W   = PROD_W + 1;

    // Stage A: pitch, block rows and end-of-chain decision
    lvl_ctrl_t            a_ctrl_reg,  a_ctrl_next;
    logic [PITCH_W-1:0]   a_pitch_reg, a_pitch_next;
    logic [WB_W-1:0]      a_hb_reg,    a_hb_next;
    logic [WB_W-1:0]      a_hbp_reg,   a_hbp_next;
    logic [TOTAL_W-1:0]   a_total_reg;
    logic [DIM_W-1:0]     a_w_reg,     a_w_next;
    logic [DIM_W-1:0]     a_h_reg,     a_h_next;
    logic                 a_stop_reg,  a_stop_next;
    logic                 a_use_u_reg, a_use_u_next;

    // Stage B: level bytes added to the total
    lvl_ctrl_t            b_ctrl_reg,  b_ctrl_next;
    logic [TOTAL_W-1:0]   b_total_reg, b_total_next;
    logic [DIM_W-1:0]     b_w_reg;
    logic [DIM_W-1:0]     b_h_reg;

    logic [WB_W-1:0]      w_ext, h_ext, wbc, hbc, wb_sum, hb_sum, wb_round;
    logic [PITCH_W-1:0]   pitch_raw, pitch_sum;
    logic                 near_tail, single, end_u, end_p;
    logic [DIM_W-1:0]     half_w, half_h;
    logic [PROD_W-1:0]    prod_p, prod_u;
    logic [LVL_W-1:0]     lvl_p, lvl_u, lvl_add;

    always_comb
    begin
        w_ext = WB_W'(prev_w);
        h_ext = WB_W'(prev_h);
        wbc   = flags.comp ? ((w_ext + WB_W'(3)) >> 2) : w_ext;
        hbc   = flags.comp ? ((h_ext + WB_W'(3)) >> 2) : h_ext;

        wb_sum   = wbc + WB_W'(TILE_BLOCKS - 1);
        hb_sum   = hbc + WB_W'(TILE_BLOCKS - 1);
        wb_round = wb_sum & ~WB_W'(TILE_BLOCKS - 1);

        pitch_raw = PITCH_W'(wb_round) * PITCH_W'(block_bytes);
        pitch_sum = pitch_raw + PITCH_W'(LINEAR_ALIGN - 1);

        near_tail = (w_ext <= WB_W'(PACK_LIMIT)) || (h_ext <= WB_W'(PACK_LIMIT));
        single    = (prev_w == DIM_W'(1)) && (prev_h == DIM_W'(1));

        // The top level ends the chain at its unpadded size unless a real
        // chain follows; lower levels end at a packed tail or at 1x1.
        if (prev_ctrl.first)
        begin
            end_u = !flags.mips || (flags.pack && near_tail) || single;
            end_p = 1'b0;
        end
        else
        begin
            end_p = flags.pack && near_tail;
            end_u = single && !end_p;
        end

        half_w = prev_w >> 1;
        half_h = prev_h >> 1;
        if (half_w == '0)
            half_w = DIM_W'(1);
        if (half_h == '0)
            half_h = DIM_W'(1);

        a_ctrl_next  = prev_ctrl;
        a_pitch_next = flags.tiled ? pitch_raw : (pitch_sum & ~PITCH_W'(LINEAR_ALIGN - 1));
        a_hb_next    = hbc;
        a_hbp_next   = hb_sum & ~WB_W'(TILE_BLOCKS - 1);
        a_w_next     = prev_ctrl.first ? pow_w : half_w;
        a_h_next     = prev_ctrl.first ? pow_h : half_h;
        a_stop_next  = end_u || end_p;
        a_use_u_next = end_u;
    end

    always_comb
    begin
        prod_p  = PROD_W'(a_pitch_reg) * PROD_W'(a_hbp_reg);
        prod_u  = PROD_W'(a_pitch_reg) * PROD_W'(a_hb_reg);
        lvl_p   = (LVL_W'(prod_p) + LVL_W'(LEVEL_ALIGN - 1)) & ~LVL_W'(LEVEL_ALIGN - 1);
        lvl_u   = (LVL_W'(prod_u) + LVL_W'(LEVEL_ALIGN - 1)) & ~LVL_W'(LEVEL_ALIGN - 1);
        lvl_add = a_use_u_reg ? lvl_u : lvl_p;

        b_total_next = a_ctrl_reg.active ? (a_total_reg + TOTAL_W'(lvl_add)) : a_total_reg;

        b_ctrl_next.valid  = a_ctrl_reg.valid;
        b_ctrl_next.active = a_ctrl_reg.active && !a_stop_reg;
        b_ctrl_next.first  = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_ctrl_reg <= '0;
            b_ctrl_reg <= '0;
        end
        else
        begin
            a_ctrl_reg <= a_ctrl_next;
            b_ctrl_reg <= b_ctrl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_pitch_reg <= a_pitch_next;
        a_hb_reg    <= a_hb_next;
        a_hbp_reg   <= a_hbp_next;
        a_total_reg <= prev_total;
        a_w_reg     <= a_w_next;
        a_h_reg     <= a_h_next;
        a_stop_reg  <= a_stop_next;
        a_use_u_reg <= a_use_u_next;
        b_total_reg <= b_total_next;
        b_w_reg     <= a_w_reg;
        b_h_reg     <= a_h_reg;
    end

    assign next_ctrl  = b_ctrl_reg;
    assign next_w     = b_w_reg;
    assign next_h     = b_h_reg;
    assign next_total = b_total_reg;

endmodule

`default_nettype wire

/* sv/tmcs_depth_scale.sv */
// Scales the chain total by the face or slice count in two half-width
// products and holds the result in the output register.
// Depends on tmcs_pkg.
`default_nettype none

module tmcs_depth_scale #(
    parameter int MAX_DEPTH = tmcs_pkg::DEF_MAX_DEPTH,
    localparam int DEPTH_W  = ($clog2(MAX_DEPTH + 1) > 3) ? $clog2(MAX_DEPTH + 1) : 3
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         src_valid,
    input  logic [tmcs_pkg::TOTAL_W-1:0] src_total,
    input  logic [DEPTH_W-1:0]           depth,
    input  logic                         bad,
    input  logic                         res_stall,
    output logic                         res_valid,
    output logic [tmcs_pkg::TOTAL_W-1:0] res_total,
    output logic                         res_bad,
    output logic                         load
);
    import tmcs_pkg::*;

    localparam int LO_W = TOTAL_W / 2;
    localparam int HI_W = TOTAL_W - LO_W;

    logic                    s1_valid_reg, s1_valid_next;
    logic [LO_W+DEPTH_W-1:0] lo_reg;
    logic [HI_W+DEPTH_W-1:0] hi_reg;
    logic                    s1_bad_reg;
    logic                    res_valid_reg, res_valid_next;
    logic [TOTAL_W-1:0]      res_total_reg;
    logic                    res_bad_reg;
    logic                    capture;

    always_comb
    begin
        // hold the products while the previous beat still waits
        load           = s1_valid_reg && !(res_valid_reg && res_stall);
        capture        = !s1_valid_reg || load;
        s1_valid_next  = (s1_valid_reg && !load) || src_valid;
        res_valid_next = load || (res_valid_reg && res_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (capture)
        begin
            lo_reg     <= (LO_W + DEPTH_W)'(src_total[LO_W-1:0]) * (LO_W + DEPTH_W)'(depth);
            hi_reg     <= (HI_W + DEPTH_W)'(src_total[TOTAL_W-1:LO_W]) *
                          (HI_W + DEPTH_W)'(depth);
            s1_bad_reg <= bad;
        end
        if (load)
        begin
            res_total_reg <= TOTAL_W'(lo_reg) + (TOTAL_W'(hi_reg) << LO_W);
            res_bad_reg   <= s1_bad_reg;
        end
    end

    assign res_valid = res_valid_reg;
    assign res_total = res_total_reg;
    assign res_bad   = res_bad_reg;

endmodule

`default_nettype wire

/* sv/tiled_mip_chain_size_core.sv */
// Tiled mip-chain size: one texture description in, its memory footprint out.
// The description is checked and clamped on entry, then a token walks a
// row of level cells, one cell per possible mip level; the chain total is
// then multiplied by the face or slice count.
// One texture is handled at a time: the next description is taken only
// once the previous total has been loaded into the output register, and a
// finished result may sit in the output register while the next texture
// runs. A volume with zero slices reports bad_request with a total of zero.
// Depends on tmcs_pkg, tmcs_level_cell and tmcs_depth_scale.
`default_nettype none

module tiled_mip_chain_size_core #(
    parameter int MAX_DIM   = tmcs_pkg::DEF_MAX_DIM,
    parameter int MAX_DEPTH = tmcs_pkg::DEF_MAX_DEPTH
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [tmcs_pkg::KIND_W-1:0]  tex_kind,
    input  logic [tmcs_pkg::BPT_W-1:0]   bits_per_texel,
    input  logic                         block_compressed,
    input  logic [tmcs_pkg::SIDE_W-1:0]  tex_width,
    input  logic [tmcs_pkg::SIDE_W-1:0]  tex_height,
    input  logic [tmcs_pkg::LAYER_W-1:0] layer_count,
    input  logic                         with_mips,
    input  logic                         tiled_layout,
    input  logic                         packed_tail,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [tmcs_pkg::TOTAL_W-1:0] total_bytes,
    output logic                         bad_request
);
    import tmcs_pkg::*;

    localparam int DIM_W   = $clog2(MAX_DIM + 1);
    localparam int DEPTH_W = ($clog2(MAX_DEPTH + 1) > 3) ? $clog2(MAX_DEPTH + 1) : 3;
    localparam int NCELL   = $clog2(MAX_DIM) + 1;

    // Largest power of two below v, at least one: first side of level one
    function automatic logic [DIM_W-1:0] pow_below(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] y;
        begin
            y = v - DIM_W'(1);
            for (int s = 1; s < DIM_W; s = s * 2)
                y = y | (y >> s);
            y = y ^ (y >> 1);
            if (y == '0)
                y = DIM_W'(1);
            return y;
        end
    endfunction

    logic                 busy_reg, busy_next;
    logic                 accept;
    logic                 scale_load;

    item_flags_t          flags_reg, flags_next;
    logic [BB_W-1:0]      bb_reg, bb_next;
    logic [DIM_W-1:0]     pow_w_reg, pow_h_reg;
    logic [DEPTH_W-1:0]   depth_reg, depth_next;
    logic                 bad_reg, bad_next;

    lvl_ctrl_t            tok_ctrl_reg, tok_ctrl_next;
    logic [DIM_W-1:0]     tok_w_reg, tok_h_reg;
    logic [DIM_W-1:0]     w_clamp, h_clamp;

    lvl_ctrl_t            ctl [0:NCELL];
    logic [DIM_W-1:0]     cw  [0:NCELL];
    logic [DIM_W-1:0]     ch  [0:NCELL];
    logic [TOTAL_W-1:0]   ct  [0:NCELL];
    logic [NCELL-1:0]     chain_valid;

    assign accept   = in_valid && !busy_reg;
    assign in_stall = busy_reg;

    always_comb
    begin
        if (tex_width == '0)
            w_clamp = DIM_W'(1);
        else if (32'(tex_width) > MAX_DIM)
            w_clamp = DIM_W'(MAX_DIM);
        else
            w_clamp = DIM_W'(tex_width);

        if (tex_height == '0)
            h_clamp = DIM_W'(1);
        else if (32'(tex_height) > MAX_DIM)
            h_clamp = DIM_W'(MAX_DIM);
        else
            h_clamp = DIM_W'(tex_height);

        flags_next.comp  = block_compressed;
        flags_next.tiled = tiled_layout;
        flags_next.pack  = packed_tail;
        flags_next.mips  = with_mips;

        bb_next = block_compressed ? {bits_per_texel, 1'b0} : BB_W'(bits_per_texel >> 3);

        bad_next = 1'b0;
        priority if (tex_kind == KIND_CUBE)
            depth_next = DEPTH_W'(CUBE_FACES);
        else if (tex_kind == KIND_VOLUME)
        begin
            if (layer_count == '0)
            begin
                // zero slices: report and let the scale force zero
                depth_next = '0;
                bad_next   = 1'b1;
            end
            else if (32'(layer_count) > MAX_DEPTH)
                depth_next = DEPTH_W'(MAX_DEPTH);
            else
                depth_next = DEPTH_W'(layer_count);
        end
        else
            depth_next = DEPTH_W'(1);

        tok_ctrl_next.valid  = accept;
        tok_ctrl_next.active = accept;
        tok_ctrl_next.first  = 1'b1;

        busy_next = accept || (busy_reg && !scale_load);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg     <= 1'b0;
            tok_ctrl_reg <= '0;
        end
        else
        begin
            busy_reg     <= busy_next;
            tok_ctrl_reg <= tok_ctrl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            flags_reg <= flags_next;
            bb_reg    <= bb_next;
            pow_w_reg <= pow_below(w_clamp);
            pow_h_reg <= pow_below(h_clamp);
            depth_reg <= depth_next;
            bad_reg   <= bad_next;
            tok_w_reg <= w_clamp;
            tok_h_reg <= h_clamp;
        end
    end

    assign ctl[0] = tok_ctrl_reg;
    assign cw[0]  = tok_w_reg;
    assign ch[0]  = tok_h_reg;
    assign ct[0]  = '0;

    for (genvar k = 0; k < NCELL; k++)
    begin : g_cell
        tmcs_level_cell #(
            .MAX_DIM (MAX_DIM)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .flags       (flags_reg),
            .block_bytes (bb_reg),
            .pow_w       (pow_w_reg),
            .pow_h       (pow_h_reg),
            .prev_ctrl   (ctl[k]),
            .prev_w      (cw[k]),
            .prev_h      (ch[k]),
            .prev_total  (ct[k]),
            .next_ctrl   (ctl[k+1]),
            .next_w      (cw[k+1]),
            .next_h      (ch[k+1]),
            .next_total  (ct[k+1])
        );
        assign chain_valid[k] = ctl[k+1].valid;
    end

    tmcs_depth_scale #(
        .MAX_DEPTH (MAX_DEPTH)
    ) u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (ctl[NCELL].valid),
        .src_total (ct[NCELL]),
        .depth     (depth_reg),
        .bad       (bad_reg),
        .res_stall (out_stall),
        .res_valid (out_valid),
        .res_total (total_bytes),
        .res_bad   (bad_request),
        .load      (scale_load)
    );

    a_accept_sets_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy_reg)
        else $error("accepted beat did not mark the block busy");

    a_single_token: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(chain_valid))
        else $error("more than one texture in the level chain");

    a_chain_finished: assert property (@(posedge clk) disable iff (!rst_n)
        ctl[NCELL].valid |-> !ctl[NCELL].active)
        else $error("mip chain still open after the last level cell");

    a_load_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        scale_load |-> busy_reg)
        else $error("result loaded with no texture in flight");

    a_bad_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && bad_request) |-> (total_bytes == '0))
        else $error("bad request carries a nonzero size");

endmodule

`default_nettype wire

/* bench/tb_top.sv */
// Self-checking bench for tiled_mip_chain_size_core: directed and random texture descriptions,
// each footprint predicted here and compared with the block's result.
// Depends on tmcs_pkg and the block's RTL only.
`timescale 1ns / 100ps

module tb_top;
    import tmcs_pkg::*;

    localparam logic [KIND_W-1:0] KIND_PLAIN  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
    localparam int MAX_DIM   = DEF_MAX_DIM;
    localparam int MAX_DEPTH = DEF_MAX_DEPTH;
    localparam int REPORT_LIMIT = 10;

    typedef struct {
        logic [KIND_W-1:0]  kind;
        logic [BPT_W-1:0]   bpt;
        logic               comp;
        logic [SIDE_W-1:0]  width;
        logic [SIDE_W-1:0]  height;
        logic [LAYER_W-1:0] layers;
        logic               mips;
        logic               tiled;
        logic               tail_packed;
    } texture_t;

    typedef struct {
        logic [TOTAL_W-1:0] total;
        logic               bad;
    } footprint_t;

    logic clk = 1'b0;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    logic [KIND_W-1:0]  tex_kind;
    logic [BPT_W-1:0]   bits_per_texel;
    logic               block_compressed;
    logic [SIDE_W-1:0]  tex_width;
    logic [SIDE_W-1:0]  tex_height;
    logic [LAYER_W-1:0] layer_count;
    logic               with_mips;
    logic               tiled_layout;
    logic               packed_tail;
    logic               out_valid;
    logic               out_stall;
    logic [TOTAL_W-1:0] total_bytes;
    logic               bad_request;

    footprint_t expected_q[$];
    int mismatch_count = 0;
    int n_sent = 0;
    int n_checked = 0;
    int n_bad = 0;
    int n_chains = 0;
    int burst_left = 0;
    bit valid_high = 1'b0;
    int stall_mode = 0;
    int stall_left = 0;

    tiled_mip_chain_size_core dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .tex_kind         (tex_kind),
        .bits_per_texel   (bits_per_texel),
        .block_compressed (block_compressed),
        .tex_width        (tex_width),
        .tex_height       (tex_height),
        .layer_count      (layer_count),
        .with_mips        (with_mips),
        .tiled_layout     (tiled_layout),
        .packed_tail      (packed_tail),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .total_bytes      (total_bytes),
        .bad_request      (bad_request)
    );

    always #5 clk = ~clk;

    // ---------------------------------------------------------------- footprint prediction

    function automatic logic [63:0] ceil_to(input logic [63:0] v, input logic [63:0] m);
        return ((v + m - 1) / m) * m;
    endfunction

    function automatic logic [63:0] pow2_at_least(input logic [63:0] v);
        logic [63:0] p;
        p = 1;
        while (p < v)
            p = p << 1;
        return p;
    endfunction

    function automatic logic [63:0] clamp_side(input logic [SIDE_W-1:0] v);
        if (v == 0)
            return 64'd1;
        if (v > MAX_DIM)
            return 64'(MAX_DIM);
        return 64'(v);
    endfunction

    // Padded level size; unpadded gets the same level at its true height
    function automatic logic [63:0] level_bytes(input logic [63:0] bpt, input logic comp,
                                                input logic [63:0] w, input logic [63:0] h,
                                                input logic tiled,
                                                output logic [63:0] unpadded);
        logic [63:0] block_sz;
        logic [63:0] wb;
        logic [63:0] hb;
        logic [63:0] pitch;
        block_sz = (bpt * (comp ? 16 : 1)) >> 3;
        wb = comp ? (w + 3) / 4 : w;
        hb = comp ? (h + 3) / 4 : h;
        pitch = ceil_to(wb, 64'(TILE_BLOCKS)) * block_sz;
        if (!tiled)
            pitch = ceil_to(pitch, 64'(LINEAR_ALIGN));
        unpadded = ceil_to(pitch * hb, 64'(LEVEL_ALIGN));
        return ceil_to(pitch * ceil_to(hb, 64'(TILE_BLOCKS)), 64'(LEVEL_ALIGN));
    endfunction

    function automatic footprint_t footprint_of(input texture_t t);
        footprint_t  r;
        logic [63:0] w;
        logic [63:0] h;
        logic [63:0] depth;
        logic [63:0] total;
        logic [63:0] last;
        logic [63:0] top;
        logic [63:0] lvl;
        logic        done;
        r.total = '0;
        r.bad   = 1'b0;
        w = clamp_side(t.width);
        h = clamp_side(t.height);
        case (t.kind)
            KIND_CUBE:   depth = 64'(CUBE_FACES);
            KIND_VOLUME:
            begin
                if (t.layers == 0)
                begin
                    r.bad = 1'b1;
                    return r;
                end
                depth = (t.layers > MAX_DEPTH) ? 64'(MAX_DEPTH) : 64'(t.layers);
            end
            default:     depth = 64'd1;
        endcase
        top = level_bytes(64'(t.bpt), t.comp, w, h, t.tiled, last);
        if (t.mips && (!t.tail_packed || (w > PACK_LIMIT && h > PACK_LIMIT)))
        begin
            w = pow2_at_least(w) >> 1;
            h = pow2_at_least(h) >> 1;
            if (w == 0 && h == 0)
                total = last;
            else
            begin
                if (w == 0) w = 1;
                if (h == 0) h = 1;
                total = top;
                done = 1'b0;
                while (!done)
                begin
                    lvl = level_bytes(64'(t.bpt), t.comp, w, h, t.tiled, last);
                    if (t.tail_packed && (w <= PACK_LIMIT || h <= PACK_LIMIT))
                    begin
                        // this level takes in the whole tail
                        total += lvl;
                        done = 1'b1;
                    end
                    else
                    begin
                        w = w >> 1;
                        h = h >> 1;
                        if (w == 0 && h == 0)
                        begin
                            total += last;
                            done = 1'b1;
                        end
                        else
                        begin
                            total += lvl;
                            if (w == 0) w = 1;
                            if (h == 0) h = 1;
                        end
                    end
                end
            end
        end
        else
            total = last;
        r.total = TOTAL_W'(total * depth);
        return r;
    endfunction

    // ---------------------------------------------------------------- sending side

    function automatic texture_t tex(input logic [KIND_W-1:0] kind, input int bpt,
                                     input bit comp, input int w, input int h,
                                     input int layers, input bit mips, input bit tiled,
                                     input bit tail_packed);
        texture_t t;
        t.kind = kind;
        t.bpt = BPT_W'(bpt);
        t.comp = comp;
        t.width = SIDE_W'(w);
        t.height = SIDE_W'(h);
        t.layers = LAYER_W'(layers);
        t.mips = mips;
        t.tiled = tiled;
        t.tail_packed = tail_packed;
        return t;
    endfunction

    // Sender works in bursts; between bursts drop valid and drive noise on the payload
    task automatic pace_sender();
        int gap;
        if (burst_left > 0)
            burst_left--;
        else
        begin
            gap = $urandom_range(1, 15);
            in_valid         <= 1'b0;
            valid_high        = 1'b0;
            tex_kind         <= KIND_W'($urandom);
            bits_per_texel   <= BPT_W'($urandom);
            block_compressed <= 1'($urandom);
            tex_width        <= SIDE_W'($urandom);
            tex_height       <= SIDE_W'($urandom);
            layer_count      <= LAYER_W'($urandom);
            with_mips        <= 1'($urandom);
            tiled_layout     <= 1'($urandom);
            packed_tail      <= 1'($urandom);
            repeat (gap) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(0, 8);
        end
    endtask

    task automatic send_texture(input texture_t t);
        tex_kind         <= t.kind;
        bits_per_texel   <= t.bpt;
        block_compressed <= t.comp;
        tex_width        <= t.width;
        tex_height       <= t.height;
        layer_count      <= t.layers;
        with_mips        <= t.mips;
        tiled_layout     <= t.tiled;
        packed_tail      <= t.tail_packed;
        in_valid         <= 1'b1;
        valid_high        = 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        expected_q.push_back(footprint_of(t));
        n_sent++;
        if (t.kind == KIND_VOLUME && t.layers == 0)
            n_bad++;
        if (t.mips)
            n_chains++;
        pace_sender();
    endtask

    // Hold off until every outstanding result has been returned
    task automatic wait_drained();
        if (valid_high)
        begin
            in_valid  <= 1'b0;
            valid_high = 1'b0;
        end
        while (expected_q.size() != 0)
            @(posedge clk);
    endtask

    // ---------------------------------------------------------------- receiving side

    always @(posedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(20, 150);
        end
        else
            stall_left--;
        case (stall_mode)
            0:       out_stall <= 1'b0;
            1:       out_stall <= ($urandom_range(0, 3) == 0);
            2:       out_stall <= ($urandom_range(0, 3) != 0);
            default: out_stall <= (stall_left > 8);
        endcase
    end

    task automatic note_mismatch(input string what, input logic [63:0] want_v,
                                 input logic [63:0] got_v);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
            $display("mismatch %0d at %0t: %s expected %0d got %0d",
                     mismatch_count, $realtime, what, want_v, got_v);
    endtask

    always @(posedge clk)
    begin : check_result
        footprint_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_q.size() == 0)
                note_mismatch("result beat with none expected, total_bytes", 64'd0,
                              64'(total_bytes));
            else
            begin
                want = expected_q.pop_front();
                n_checked++;
                if (total_bytes !== want.total)
                    note_mismatch("total_bytes", 64'(want.total), 64'(total_bytes));
                if (bad_request !== want.bad)
                    note_mismatch("bad_request", 64'(want.bad), 64'(bad_request));
            end
        end
    end

    // ---------------------------------------------------------------- tests

    task automatic test_edge_sizes();
        send_texture(tex(KIND_PLAIN, 4, 0, 1, 1, 0, 0, 1, 0));
        send_texture(tex(KIND_PLAIN, 128, 0, 16384, 16384, 0, 1, 1, 0));
        send_texture(tex(KIND_CUBE, 128, 1, 16384, 16384, 0, 1, 0, 1));
        send_texture(tex(KIND_VOLUME, 64, 0, 16384, 1, 2048, 1, 0, 0));
        send_texture(tex(KIND_PLAIN, 32, 0, 1, 16384, 0, 1, 1, 0));
        send_texture(tex(KIND_VOLUME, 4, 1, 4, 4, 1, 0, 1, 0));
    endtask

    task automatic test_special_cases();
        // single texel: the chain has just the one level, unpacked or packed
        send_texture(tex(KIND_PLAIN, 32, 0, 1, 1, 0, 1, 1, 0));
        send_texture(tex(KIND_PLAIN, 32, 0, 1, 1, 0, 1, 1, 1));
        // zero sides read as one texel
        send_texture(tex(KIND_PLAIN, 16, 0, 0, 0, 0, 1, 0, 0));
        // oversized sides saturate
        send_texture(tex(KIND_CUBE, 8, 0, 32767, 20000, 0, 1, 1, 0));
        send_texture(tex(KIND_UNUSED, 32, 0, 512, 512, 7, 1, 1, 0));
        send_texture(tex(KIND_PLAIN, 0, 0, 300, 200, 0, 1, 0, 0));
        send_texture(tex(KIND_PLAIN, 255, 1, 777, 333, 0, 1, 0, 1));
        send_texture(tex(KIND_VOLUME, 32, 0, 64, 64, 0, 1, 1, 0));
        send_texture(tex(KIND_VOLUME, 16, 0, 40, 40, 4095, 1, 1, 0));
        // packed chain that never starts, and one that starts just above the limit
        send_texture(tex(KIND_PLAIN, 32, 0, 16, 4096, 0, 1, 1, 1));
        send_texture(tex(KIND_PLAIN, 32, 0, 17, 17, 0, 1, 1, 1));
    endtask

    task automatic test_layouts();
        for (int combo = 0; combo < 8; combo++)
            send_texture(tex(KIND_PLAIN, 32, combo[0], 1000, 300, 0, 1, combo[1], combo[2]));
    endtask

    function automatic int pick_side();
        int e;
        case ($urandom_range(0, 5))
            0: return $urandom_range(1, 16);
            1: return $urandom_range(17, 64);
            2: return 1 << $urandom_range(0, 14);
            3: return $urandom_range(1, MAX_DIM);
            4:
            begin
                e = $urandom_range(1, 14);
                return (1 << e) + ($urandom_range(0, 1) ? 1 : -1);
            end
            default: return $urandom_range(1, 512);
        endcase
    endfunction

    function automatic texture_t random_texture();
        texture_t t;
        int bpt_set[8] = '{4, 8, 16, 24, 32, 64, 96, 128};
        if ($urandom_range(0, 4) == 0)
        begin
            // out-of-range noise over the full width of every field
            t.kind = KIND_W'($urandom);
            t.bpt = BPT_W'($urandom);
            t.comp = 1'($urandom);
            t.width = SIDE_W'($urandom);
            t.height = SIDE_W'($urandom);
            t.layers = LAYER_W'($urandom);
            t.mips = 1'($urandom);
            t.tiled = 1'($urandom);
            t.tail_packed = 1'($urandom);
        end
        else
        begin
            t.kind = KIND_W'($urandom_range(0, 2));
            t.bpt = $urandom_range(0, 1) ? BPT_W'(bpt_set[$urandom_range(0, 7)])
                                         : BPT_W'($urandom_range(4, 128));
            t.comp = 1'($urandom);
            t.width = SIDE_W'(pick_side());
            t.height = SIDE_W'(pick_side());
            t.layers = ($urandom_range(0, 15) == 0) ? LAYER_W'(0) :
                       ($urandom_range(0, 3) == 0) ? LAYER_W'($urandom_range(1, MAX_DEPTH))
                                                   : LAYER_W'($urandom_range(1, 16));
            t.mips = ($urandom_range(0, 3) != 0);
            t.tiled = 1'($urandom);
            t.tail_packed = 1'($urandom);
        end
        return t;
    endfunction

    task automatic test_random_textures(input int count);
        for (int i = 0; i < count; i++)
        begin
            send_texture(random_texture());
            // now and then let the pipe empty completely mid-stream
            if ($urandom_range(0, 99) == 0)
                wait_drained();
        end
    endtask

    // ---------------------------------------------------------------- run

    initial
    begin
        rst_n            <= 1'b0;
        in_valid         <= 1'b0;
        out_stall        <= 1'b0;
        tex_kind         <= '0;
        bits_per_texel   <= '0;
        block_compressed <= 1'b0;
        tex_width        <= '0;
        tex_height       <= '0;
        layer_count      <= '0;
        with_mips        <= 1'b0;
        tiled_layout     <= 1'b0;
        packed_tail      <= 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_edge_sizes();
        wait_drained();
        test_special_cases();
        wait_drained();
        test_layouts();
        wait_drained();
        test_random_textures(550);
        wait_drained();
        repeat (40) @(posedge clk);

        $display("run covered %0d texture descriptions, %0d with mip chains,",
                 n_sent, n_chains);
        $display("%0d zero-depth volumes; %0d results compared, %0d mismatches",
                 n_bad, n_checked, mismatch_count);
        if (mismatch_count == 0)
            $display("PASS tiled_mip_chain_size_core");
        else
            $display("FAIL tiled_mip_chain_size_core");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("timeout: %0d results still outstanding", expected_q.size());
        $display("FAIL tiled_mip_chain_size_core");
        $finish;
    end

endmodule

/* tiled_mip_chain_size_core.f */
sv/tmcs_pkg.sv
sv/tmcs_level_cell.sv
sv/tmcs_depth_scale.sv
sv/tiled_mip_chain_size_core.sv
bench/tb_top.sv
